@@ hdl/cn2d_pkg.sv @@
// Shared widths and constants for the 2D cellular noise core.
// No dependencies; imported by every module of the core.
package cn2d_pkg;

   localparam int COORD_W          = 32;
   localparam int DENS_W           = 24;
   localparam int DENS_FRAC        = 16;
   localparam logic [DENS_W-1:0] DENS_RESET = 24'd65536;
   localparam int WORK_BITS        = 24;
   localparam int DEF_FRAC_BITS    = 16;
   localparam int DEF_OFFSET_BITS  = 24;

   localparam logic [31:0] HMUL1   = 32'h7feb352d;
   localparam logic [31:0] HMUL2   = 32'h846ca68b;
   localparam logic [31:0] HGOLD   = 32'h9e3779b9;
   localparam logic [31:0] HSHIFT  = 32'h0000_1000;

   localparam int DIFF_W     = WORK_BITS + 2;   // signed offset difference
   localparam int D2_W       = 2 * WORK_BITS + 3;
   localparam int RAD_W      = 36;              // radicand (d2 >> 16), padded even
   localparam int ROOT_W     = RAD_W / 2;
   localparam int SQ_STAGES  = ROOT_W / 2;      // two root bits per stage

   localparam int SUM_W      = ROOT_W + 1;
   localparam int REM_W      = SUM_W + 1;
   localparam int QUO_W      = 17;              // quotient up to 1.0 in Q1.16
   localparam int DIV_STAGES = (QUO_W + 1) / 2; // two quotient bits per stage
   localparam int EDGE_W     = 16;

endpackage

@@ hdl/cn2d_isqrt.sv @@
// Pipelined integer square root, two result bits per stage.
// Depends on cn2d_pkg.
module cn2d_isqrt import cn2d_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   logic [ROOT_W+1:0] rem_ff  [SQ_STAGES];
   logic [ROOT_W-1:0] root_ff [SQ_STAGES];
   logic [RAD_W-1:0]  rad_ff  [SQ_STAGES];

   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
      logic [ROOT_W+1:0] rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RAD_W-1:0]  rad_in;

      always_comb begin
         logic [ROOT_W+3:0] trial_rem;
         logic [ROOT_W+3:0] trial_sub;
         if (g == 0) begin
            rem_in  = '0;
            root_in = '0;
            rad_in  = radicand;
         end else begin
            rem_in  = rem_ff[g-1];
            root_in = root_ff[g-1];
            rad_in  = rad_ff[g-1];
         end
         for (int k = 0; k < 2; k++) begin
            trial_rem = {rem_in, rad_in[RAD_W-1-2*(2*g+k) -: 2]};
            trial_sub = {2'b00, root_in, 2'b01};
            if (trial_rem >= trial_sub) begin
               rem_in  = (ROOT_W+2)'(trial_rem - trial_sub);
               root_in = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = trial_rem[ROOT_W+1:0];
               root_in = {root_in[ROOT_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            rad_ff[g]  <= rad_in;
         end
      end
   end

   assign root = root_ff[SQ_STAGES-1];

endmodule

@@ hdl/cn2d_div.sv @@
// Pipelined restoring divider for a quotient in [0, 1.0] with 16 fraction bits.
// Depends on cn2d_pkg. Dividend must not exceed the divisor.
module cn2d_div import cn2d_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic [ROOT_W-1:0] dividend,
   input  logic [SUM_W-1:0]  divisor,
   output logic [QUO_W-1:0]  quotient
);

   logic [REM_W-1:0] rem_ff [DIV_STAGES];
   logic [SUM_W-1:0] dsr_ff [DIV_STAGES];
   logic [QUO_W-1:0] quo_ff [DIV_STAGES];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      logic [REM_W-1:0] rem_in;
      logic [SUM_W-1:0] dsr_in;
      logic [QUO_W-1:0] quo_in;

      always_comb begin
         if (g == 0) begin
            rem_in = REM_W'(dividend);
            dsr_in = divisor;
            quo_in = '0;
         end else begin
            rem_in = rem_ff[g-1];
            dsr_in = dsr_ff[g-1];
            quo_in = quo_ff[g-1];
         end
         for (int k = 0; k < 2; k++) begin
            if (2*g + k < QUO_W) begin
               if (2*g + k != 0) begin
                  rem_in = {rem_in[REM_W-2:0], 1'b0};
               end
               if (rem_in >= REM_W'(dsr_in)) begin
                  rem_in = rem_in - REM_W'(dsr_in);
                  quo_in = {quo_in[QUO_W-2:0], 1'b1};
               end else begin
                  quo_in = {quo_in[QUO_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g] <= rem_in;
            dsr_ff[g] <= dsr_in;
            quo_ff[g] <= quo_in;
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

@@ hdl/cellular_noise_2d_core.sv @@
// 2D cellular (Worley) noise core, F1/F2 with cell-edge value.
// Depends on cn2d_pkg, cn2d_isqrt and cn2d_div.
//
// Takes one point word per clock and returns one result word per point, in order.
// The pipeline has 13 stages for scaling, hashing the 3x3 neighbor cells, squared
// distances and the two-smallest tree, 9 stages for the two square roots, one for
// sum and difference, 9 for the edge-value divider, and the output register. A new
// word is taken every clock while the output register is empty or being read;
// when the consumer holds rsp_tready low with a word waiting, the whole pipeline
// freezes in place. The density register is written through csr_wr_en/csr_wr_data
// and resets to 1.0.
module cellular_noise_2d_core import cn2d_pkg::*; #(
   parameter int FRAC_BITS   = DEF_FRAC_BITS,
   parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_wr_en,
   input  logic [DENS_W-1:0] csr_wr_data,   // density, Q8.16
   // point words
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,     // [31:0] x_coord, [63:32] y_coord
   // result words
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [55:0]       rsp_tdata,     // [17:0] near_dist, [35:18] second_dist,
                                            // [51:36] edge_value, [55:52] zero
   output logic              rsp_tuser      // [0] saturated
);

   localparam int LAT = 13 + SQ_STAGES + 1 + DIV_STAGES + 1;

   typedef struct packed {
      logic [D2_W-1:0] d1;
      logic [D2_W-1:0] d2;
   } cn2d_pair_type;

   typedef struct packed {
      logic [ROOT_W-1:0] s1;
      logic [ROOT_W-1:0] s2;
      logic              zero;
      logic              sat;
   } cn2d_side_type;

   localparam logic [D2_W-1:0] D2_MAX = '1;

   // mix32 pieces; the multiplies sit between them in separate stages
   function automatic logic [31:0] pre1(input logic [31:0] v);
      return v ^ (v >> 16);
   endfunction

   function automatic logic [31:0] pre2(input logic [31:0] v);
      return v ^ (v >> 15);
   endfunction

   function automatic logic [31:0] fin(input logic [31:0] v);
      return v ^ (v >> 16);
   endfunction

   // merge two (smallest, second smallest) pairs
   function automatic cn2d_pair_type merge(input cn2d_pair_type a, input cn2d_pair_type b);
      cn2d_pair_type r;
      if (a.d1 <= b.d1) begin
         r.d1 = a.d1;
         r.d2 = (a.d2 < b.d1) ? a.d2 : b.d1;
      end else begin
         r.d1 = b.d1;
         r.d2 = (b.d2 < a.d1) ? b.d2 : a.d1;
      end
      return r;
   endfunction

   // clamp a 41-bit floor-scaled coordinate to 32 bits: {sat, value}
   function automatic logic [32:0] clamp32(input logic [40:0] q);
      if (q[40:31] != {10{q[31]}}) begin
         return q[40] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7fff_ffff};
      end
      return {1'b0, q[31:0]};
   endfunction

   // ---------------------------------------------------------------- control
   logic [DENS_W-1:0] density_ff;
   logic [LAT-1:0]    vld_ff;
   logic              pipe_en;

   assign pipe_en    = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = pipe_en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         density_ff <= DENS_RESET;
         vld_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            density_ff <= csr_wr_data;
         end
         if (pipe_en) begin
            vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
         end
      end
   end

   // ---------------------------------------------------- stage 1: scale multiply
   logic signed [56:0] px_ff, py_ff, px_in, py_in;

   always_comb begin
      px_in = $signed(req_tdata[31:0])  * $signed({1'b0, density_ff});
      py_in = $signed(req_tdata[63:32]) * $signed({1'b0, density_ff});
   end

   // -------------------------------------------- stage 2: clamp, cell, fraction
   logic [31:0]          cx_ff, cy_ff, cx_in, cy_in;
   logic [WORK_BITS-1:0] fx2_ff, fy2_ff, fx2_in, fy2_in;
   logic                 sat2_ff, sat2_in;

   always_comb begin
      logic [32:0] clx;
      logic [32:0] cly;
      clx     = clamp32(px_ff[56:DENS_FRAC]);
      cly     = clamp32(py_ff[56:DENS_FRAC]);
      sat2_in = clx[32] | cly[32];
      cx_in   = 32'($signed(clx[31:0]) >>> FRAC_BITS);
      cy_in   = 32'($signed(cly[31:0]) >>> FRAC_BITS);
      fx2_in  = WORK_BITS'(clx[FRAC_BITS-1:0]) << (WORK_BITS - FRAC_BITS);
      fy2_in  = WORK_BITS'(cly[FRAC_BITS-1:0]) << (WORK_BITS - FRAC_BITS);
   end

   // ------------------------ stages 3..6: hashes (first mix on x, second on h^y)
   // x lane j: cell x + (j mod 3) - 1, plus HSHIFT for j >= 3
   // y lane k: cell y + (k mod 3) - 1, minus HSHIFT for k >= 3, times HGOLD
   logic [31:0] ma1_ff [6];
   logic [31:0] ma2_ff [6];
   logic [31:0] gy3_ff [6];
   logic [31:0] gy4_ff [6];
   logic [31:0] mb1_ff [18];
   logic [31:0] mb2_ff [18];
   logic [31:0] ma1_in [6];
   logic [31:0] ma2_in [6];
   logic [31:0] gy3_in [6];
   logic [31:0] mb1_in [18];
   logic [31:0] mb2_in [18];

   for (genvar j = 0; j < 6; j++) begin : g_lane
      always_comb begin
         logic [31:0] gx;
         logic [31:0] gy;
         if (j < 3) begin
            gx = cx_ff + 32'(j - 1);
            gy = cy_ff + 32'(j - 1);
         end else begin
            gx = cx_ff + 32'(j - 4) + HSHIFT;
            gy = cy_ff + 32'(j - 4) - HSHIFT;
         end
         ma1_in[j] = pre1(gx) * HMUL1;
         gy3_in[j] = gy * HGOLD;
         ma2_in[j] = pre2(ma1_ff[j]) * HMUL2;
      end
   end

   // hash h < 9 places x of cell h, h >= 9 places y of cell h-9
   for (genvar h = 0; h < 18; h++) begin : g_hash
      localparam int C  = h % 9;
      localparam int LX = (C % 3) + ((h >= 9) ? 3 : 0);
      localparam int LY = (C / 3) + ((h >= 9) ? 3 : 0);
      always_comb begin
         mb1_in[h] = pre1(fin(ma2_ff[LX]) ^ gy4_ff[LY]) * HMUL1;
         mb2_in[h] = pre2(mb1_ff[h]) * HMUL2;
      end
   end

   logic [WORK_BITS-1:0] fx3_ff, fy3_ff, fx4_ff, fy4_ff, fx5_ff, fy5_ff, fx6_ff, fy6_ff;
   logic                 sat3_ff, sat4_ff, sat5_ff, sat6_ff;

   // ------------------------------------- stage 7: offsets and differences
   logic signed [DIFF_W-1:0] dx_ff [9];
   logic signed [DIFF_W-1:0] dy_ff [9];
   logic signed [DIFF_W-1:0] dx_in [9];
   logic signed [DIFF_W-1:0] dy_in [9];
   logic                     sat7_ff;

   // ------------------------------------- stage 8: squares, stage 9: d2
   logic [D2_W-2:0] sqx_ff [9];
   logic [D2_W-2:0] sqy_ff [9];
   logic [D2_W-2:0] sqx_in [9];
   logic [D2_W-2:0] sqy_in [9];
   logic [D2_W-1:0] d2_ff  [9];
   logic            sat8_ff, sat9_ff;

   for (genvar c = 0; c < 9; c++) begin : g_cell
      localparam logic signed [DIFF_W-1:0] BASE_X = DIFF_W'(((c % 3) - 1) * (1 << WORK_BITS));
      localparam logic signed [DIFF_W-1:0] BASE_Y = DIFF_W'(((c / 3) - 1) * (1 << WORK_BITS));
      always_comb begin
         logic [WORK_BITS-1:0]  offx;
         logic [WORK_BITS-1:0]  offy;
         logic signed [2*DIFF_W-1:0] tx;
         logic signed [2*DIFF_W-1:0] ty;
         offx = WORK_BITS'(fin(mb2_ff[c])     >> (32 - OFFSET_BITS)) << (WORK_BITS - OFFSET_BITS);
         offy = WORK_BITS'(fin(mb2_ff[9 + c]) >> (32 - OFFSET_BITS)) << (WORK_BITS - OFFSET_BITS);
         dx_in[c] = BASE_X + $signed({2'b00, offx}) - $signed({2'b00, fx6_ff});
         dy_in[c] = BASE_Y + $signed({2'b00, offy}) - $signed({2'b00, fy6_ff});
         tx = dx_ff[c] * dx_ff[c];
         ty = dy_ff[c] * dy_ff[c];
         sqx_in[c] = tx[D2_W-2:0];
         sqy_in[c] = ty[D2_W-2:0];
      end
   end

   // ---------------------------------- stages 10..13: two-smallest tree
   cn2d_pair_type l1_ff [5];
   cn2d_pair_type l2_ff [3];
   cn2d_pair_type l3_ff [2];
   cn2d_pair_type best_ff;
   logic          sat10_ff, sat11_ff, sat12_ff, sat13_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         px_ff   <= px_in;
         py_ff   <= py_in;

         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         fx2_ff  <= fx2_in;
         fy2_ff  <= fy2_in;
         sat2_ff <= sat2_in;

         for (int j = 0; j < 6; j++) begin
            ma1_ff[j] <= ma1_in[j];
            gy3_ff[j] <= gy3_in[j];
            ma2_ff[j] <= ma2_in[j];
            gy4_ff[j] <= gy3_ff[j];
         end
         for (int h = 0; h < 18; h++) begin
            mb1_ff[h] <= mb1_in[h];
            mb2_ff[h] <= mb2_in[h];
         end
         fx3_ff <= fx2_ff;  fy3_ff <= fy2_ff;  sat3_ff <= sat2_ff;
         fx4_ff <= fx3_ff;  fy4_ff <= fy3_ff;  sat4_ff <= sat3_ff;
         fx5_ff <= fx4_ff;  fy5_ff <= fy4_ff;  sat5_ff <= sat4_ff;
         fx6_ff <= fx5_ff;  fy6_ff <= fy5_ff;  sat6_ff <= sat5_ff;

         for (int c = 0; c < 9; c++) begin
            dx_ff[c]  <= dx_in[c];
            dy_ff[c]  <= dy_in[c];
            sqx_ff[c] <= sqx_in[c];
            sqy_ff[c] <= sqy_in[c];
            d2_ff[c]  <= {1'b0, sqx_ff[c]} + {1'b0, sqy_ff[c]};
         end
         sat7_ff <= sat6_ff;
         sat8_ff <= sat7_ff;
         sat9_ff <= sat8_ff;

         for (int p = 0; p < 4; p++) begin
            l1_ff[p] <= merge('{d1: d2_ff[2*p],     d2: D2_MAX},
                              '{d1: d2_ff[2*p + 1], d2: D2_MAX});
         end
         l1_ff[4]  <= '{d1: d2_ff[8], d2: D2_MAX};
         sat10_ff  <= sat9_ff;
         l2_ff[0]  <= merge(l1_ff[0], l1_ff[1]);
         l2_ff[1]  <= merge(l1_ff[2], l1_ff[3]);
         l2_ff[2]  <= l1_ff[4];
         sat11_ff  <= sat10_ff;
         l3_ff[0]  <= merge(l2_ff[0], l2_ff[1]);
         l3_ff[1]  <= l2_ff[2];
         sat12_ff  <= sat11_ff;
         best_ff   <= merge(l3_ff[0], l3_ff[1]);
         sat13_ff  <= sat12_ff;
      end
   end

   // ---------------------------------------------- square roots of d2 >> 16
   logic [ROOT_W-1:0] root_a, root_b;
   logic              satq_ff [SQ_STAGES];

   cn2d_isqrt u_sqrt_near (
      .clock    (clock),
      .enable   (pipe_en),
      .radicand (RAD_W'(best_ff.d1 >> 16)),
      .root     (root_a)
   );

   cn2d_isqrt u_sqrt_second (
      .clock    (clock),
      .enable   (pipe_en),
      .radicand (RAD_W'(best_ff.d2 >> 16)),
      .root     (root_b)
   );

   // ------------------------------------- sum / difference, then divider
   logic [ROOT_W-1:0] s1_ff, s2_ff, diff_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic              satr_ff;
   cn2d_side_type     side_ff [DIV_STAGES];
   logic [QUO_W-1:0]  quo;

   cn2d_div u_div (
      .clock    (clock),
      .enable   (pipe_en),
      .dividend (diff_ff),
      .divisor  (sum_ff),
      .quotient (quo)
   );

   // ------------------------------------------------------- output register
   logic [ROOT_W-1:0] near_ff, second_ff;
   logic [EDGE_W-1:0] edge_ff, edge_in;
   logic              sato_ff;

   always_comb begin
      if (side_ff[DIV_STAGES-1].zero) begin
         edge_in = '0;                       // both distances zero
      end else if (quo[QUO_W-1]) begin
         edge_in = '1;                       // quotient of exactly 1.0
      end else begin
         edge_in = quo[EDGE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         satq_ff[0] <= sat13_ff;
         for (int s = 1; s < SQ_STAGES; s++) begin
            satq_ff[s] <= satq_ff[s-1];
         end

         s1_ff   <= root_a;
         s2_ff   <= root_b;
         diff_ff <= root_b - root_a;         // second is never below near
         sum_ff  <= SUM_W'(root_a) + SUM_W'(root_b);
         satr_ff <= satq_ff[SQ_STAGES-1];

         side_ff[0] <= '{s1: s1_ff, s2: s2_ff, zero: (sum_ff == '0), sat: satr_ff};
         for (int s = 1; s < DIV_STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end

         near_ff   <= side_ff[DIV_STAGES-1].s1;
         second_ff <= side_ff[DIV_STAGES-1].s2;
         edge_ff   <= edge_in;
         sato_ff   <= side_ff[DIV_STAGES-1].sat;
      end
   end

   assign rsp_tdata = {4'b0000, edge_ff, second_ff, near_ff};
   assign rsp_tuser = sato_ff;

endmodule

@@ tb/cn2d_checker.sv @@
// Result checker for the 2D cellular noise core: watches point and result words,
// predicts each result and compares it field by field. Depends on cn2d_pkg.
`timescale 1ns / 100ps
module cn2d_checker import cn2d_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [DENS_W-1:0] csr_wr_data,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [63:0]       req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [55:0]       rsp_tdata,
   input  logic              rsp_tuser,
   output int                fail_count,
   output int                pending,
   output int                checked
);

   typedef struct packed {
      logic [17:0] near_dist;
      logic [17:0] second_dist;
      logic [15:0] edge_value;
      logic        saturated;
   } noise_type;

   logic [DENS_W-1:0] dens;
   noise_type         expected_q[$];

   function automatic logic [31:0] avalanche(logic [31:0] v);
      v = v ^ (v >> 16);
      v = v * HMUL1;
      v = v ^ (v >> 15);
      v = v * HMUL2;
      v = v ^ (v >> 16);
      return v;
   endfunction

   function automatic logic [31:0] hash_cell(logic [31:0] cx, logic [31:0] cy);
      logic [31:0] t;
      t = cy * HGOLD;
      return avalanche(avalanche(cx) ^ t);
   endfunction

   function automatic longint scale_axis(logic signed [31:0] c, ref logic sat);
      longint p;
      longint q;
      p = longint'(c) * longint'({8'd0, dens});
      q = p >>> DENS_FRAC;
      if (q > 64'sd2147483647) begin
         q = 64'sd2147483647;
         sat = 1'b1;
      end
      if (q < -64'sd2147483648) begin
         q = -64'sd2147483648;
         sat = 1'b1;
      end
      return q;
   endfunction

   function automatic logic [63:0] int_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic noise_type predict_noise(logic [63:0] word);
      noise_type  res;
      logic       sat;
      longint     qx, qy, cellx, celly, fx, fy, dx, dy, offx, offy;
      logic [31:0] gx, gy, hx, hy;
      logic [63:0] d2, best1, best2, s1, s2, sum, edge_q;
      sat = 1'b0;
      qx = scale_axis(word[31:0], sat);
      qy = scale_axis(word[63:32], sat);
      cellx = qx >>> DEF_FRAC_BITS;
      celly = qy >>> DEF_FRAC_BITS;
      fx = (qx & 64'hffff) << (WORK_BITS - DEF_FRAC_BITS);
      fy = (qy & 64'hffff) << (WORK_BITS - DEF_FRAC_BITS);
      best1 = '1;
      best2 = '1;
      for (int oy = -1; oy <= 1; oy++) begin
         for (int ox = -1; ox <= 1; ox++) begin
            gx = 32'(cellx + ox);
            gy = 32'(celly + oy);
            hx = hash_cell(gx, gy);
            hy = hash_cell(gx + HSHIFT, gy - HSHIFT);
            offx = longint'(hx >> (32 - DEF_OFFSET_BITS));
            offy = longint'(hy >> (32 - DEF_OFFSET_BITS));
            dx = longint'(ox) * (64'sd1 << WORK_BITS) + offx - fx;
            dy = longint'(oy) * (64'sd1 << WORK_BITS) + offy - fy;
            d2 = dx * dx + dy * dy;
            if (d2 < best1) begin
               best2 = best1;
               best1 = d2;
            end else if (d2 < best2) begin
               best2 = d2;
            end
         end
      end
      s1 = int_root(best1 >> 16);
      s2 = int_root(best2 >> 16);
      if (s1 > 262143) s1 = 262143;
      if (s2 > 262143) s2 = 262143;
      sum = s1 + s2;
      edge_q = 0;
      if (sum != 0) begin
         edge_q = (((s2 >= s1) ? s2 - s1 : 64'd0) << 16) / sum;
         if (edge_q > 65535) edge_q = 65535;
      end
      res.near_dist   = s1[17:0];
      res.second_dist = s2[17:0];
      res.edge_value  = edge_q[15:0];
      res.saturated   = sat;
      return res;
   endfunction

   always @(posedge clock) begin
      noise_type want;
      noise_type got;
      if (reset) begin
         dens       <= DENS_RESET;
         fail_count <= 0;
         checked    <= 0;
         expected_q.delete();
      end else begin
         if (csr_wr_en) dens <= csr_wr_data;
         if (req_tvalid && req_tready) expected_q.push_back(predict_noise(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[17:0], rsp_tdata[35:18], rsp_tdata[51:36], rsp_tuser};
            checked <= checked + 1;
            if (expected_q.size() == 0) begin
               $error("result word with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got != want || rsp_tdata[55:52] != 0) begin
                  fail_count <= fail_count + 1;
                  if (got.near_dist != want.near_dist)
                     $error("near_dist exp %0d got %0d", want.near_dist, got.near_dist);
                  if (got.second_dist != want.second_dist)
                     $error("second_dist exp %0d got %0d", want.second_dist,
                            got.second_dist);
                  if (got.edge_value != want.edge_value)
                     $error("edge_value exp %0d got %0d", want.edge_value, got.edge_value);
                  if (got.saturated != want.saturated)
                     $error("saturated exp %0d got %0d", want.saturated, got.saturated);
                  if (rsp_tdata[55:52] != 0)
                     $error("pad bits exp 0 got %0h", rsp_tdata[55:52]);
               end
            end
         end
      end
   end

   assign pending = expected_q.size();

endmodule

@@ tb/testbench.sv @@
// Stimulus and verdict for cellular_noise_2d_core.
// Depends on cn2d_pkg, the core and cn2d_checker.
`timescale 1ns / 100ps
module testbench;
   import cn2d_pkg::*;

   localparam int LATENCY   = 33;
   localparam int MAX_CYCLE = 400000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [DENS_W-1:0] csr_wr_data = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [63:0]       req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [55:0]       rsp_tdata;
   logic              rsp_tuser;
   int                fail_count, pending, checked;
   int                cycle = 0;
   int                points_sent = 0;
   bit                hold_off = 1'b0;    // long consumer stall request
   bit                steady_rsp = 1'b0;  // consumer always ready

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   cellular_noise_2d_core u_dut (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   cn2d_checker u_check (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .pending, .checked
   );

   // watchdog
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("[cellular_noise_2d_core] ERROR");
         $finish;
      end
   end

   // consumer: own stall pattern, plus long hold-off on request
   always @(negedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else if (steady_rsp) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 9) < 7);
   end

   // one word, waiting for the handshake; burst gaps are handled by the caller
   task automatic send_point(logic [31:0] x, logic [31:0] y);
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      points_sent++;
   endtask

   task automatic idle_point(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // pause sender until all results are back, then the pipe drains; then write density
   task automatic set_density(logic [DENS_W-1:0] d);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random point: mostly modest coordinates, sometimes full range
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
         default: return 32'($signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000);
      endcase
   endfunction

   task automatic random_phase(int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && n > 0; i++, n--) send_point(rand_coord(), rand_coord());
         if ($urandom_range(0, 2) != 0) idle_point($urandom_range(1, 6));
      end
   endtask

   logic [DENS_W-1:0] dens_list[6] = '{24'h010000, 24'hffffff, 24'h000000,
                                       24'h000001, 24'h004000, 24'h080000};

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset density 1.0: extremes, zero, cell corners, wrap
      steady_rsp = 1'b1;
      send_point(32'h0, 32'h0);
      send_point(32'h7fffffff, 32'h7fffffff);
      send_point(32'h80000000, 32'h80000000);
      send_point(32'h7fffffff, 32'h80000000);
      send_point(32'hffffffff, 32'h00000001);
      send_point(32'h0000ffff, 32'hffff0000);
      send_point(32'h00010000, 32'h00008000);
      send_point(32'haaaaaaaa, 32'h55555555);
      send_point(32'h55555555, 32'haaaaaaaa);
      set_density(24'hffffff);          // max scale: the two extreme points saturate
      send_point(32'h00010000, 32'hffff0000);
      send_point(32'h00000100, 32'h00000000);
      send_point(32'h7fffffff, 32'h00000000);
      send_point(32'h80000000, 32'h00000001);
      set_density(24'h000000);          // zero scale: all points in cell 0
      send_point(32'h12345678, 32'h87654321);
      send_point(32'h80000000, 32'h7fffffff);
      steady_rsp = 1'b0;

      // random phases across several densities
      foreach (dens_list[i]) begin
         set_density(dens_list[i]);
         random_phase(280);
         if (i == 2) begin
            // long consumer stall while the sender keeps offering
            fork
               begin
                  hold_off = 1'b1;
                  repeat (200) @(negedge clock);
                  hold_off = 1'b0;
               end
               random_phase(60);
            join
         end
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      $display("Covered %0d point words, %0d results checked, six density settings,",
               points_sent, checked);
      $display("saturating and zero scales, extreme coordinates and a long output stall.");
      if (fail_count == 0 && pending == 0)
         $display("[cellular_noise_2d_core] OK");
      else
         $display("[cellular_noise_2d_core] ERROR");
      $finish;
   end

endmodule
